@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL that checks itself.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/nus_pkg.sv @@
// Shared types and constants for the NMEA/UBX frame splitter.
// No dependencies; used by nus_tracker and nmea_ubx_frame_splitter_top.
package nus_pkg;

  // UBX framing: length field position and header plus checksum overhead
  localparam logic [16:0] LENGTH_FIELD_OFFSET     = 17'd4;
  localparam logic [16:0] HEADER_AND_CHECKSUM_LEN = 17'd8;

  // Configuration register indexes
  localparam logic [2:0] CFG_NMEA_START  = 3'd0;
  localparam logic [2:0] CFG_NMEA_END    = 3'd1;
  localparam logic [2:0] CFG_UBX_SYNC1   = 3'd2;
  localparam logic [2:0] CFG_UBX_SYNC2   = 3'd3;
  localparam logic [2:0] CFG_LEN_BIG_END = 3'd4;

  // Configuration reset values
  localparam logic [7:0] NMEA_START_RST = 8'd36;
  localparam logic [7:0] NMEA_END_RST   = 8'd10;
  localparam logic [7:0] UBX_SYNC1_RST  = 8'd181;
  localparam logic [7:0] UBX_SYNC2_RST  = 8'd98;

  typedef enum logic [1:0] {
    ST_DISCARD   = 2'd0,
    ST_CAPTURING = 2'd1,
    ST_DONE      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PROTO_NONE = 2'd0,
    PROTO_NMEA = 2'd1,
    PROTO_UBX  = 2'd2
  } proto_t;

  typedef struct packed {
    logic [7:0] nmea_start;
    logic [7:0] nmea_end;
    logic [7:0] ubx_sync1;
    logic [7:0] ubx_sync2;
    logic       len_big_end;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    proto_t      proto;
    logic [15:0] plen;
  } tag_t;

endpackage

@@ src/nus_tracker.sv @@
// Frame tracker: phase, UBX byte offset and captured length, plus the tag of each byte.
// Depends on nus_pkg.
module nus_tracker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  input  nus_pkg::cfg_t   cfg,
  output nus_pkg::tag_t   tag
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SYNC2 = 2'd1,
    PH_NMEA  = 2'd2,
    PH_UBX   = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [16:0] offset_r, offset_nxt;
  logic [15:0] caplen_r, caplen_nxt;

  logic [15:0] ubx_len;
  logic [16:0] ubx_off_inc;
  logic        ubx_done;
  logic        discard;
  logic        done;

  // UBX byte handling, shared by the second sync byte and the frame body
  always_comb begin
    ubx_len = caplen_r;
    if (offset_r == nus_pkg::LENGTH_FIELD_OFFSET) begin
      if (cfg.len_big_end) ubx_len[15:8] = rx_byte;
      else                 ubx_len[7:0]  = rx_byte;
    end else if (offset_r == nus_pkg::LENGTH_FIELD_OFFSET + 17'd1) begin
      if (cfg.len_big_end) ubx_len[7:0]  = rx_byte;
      else                 ubx_len[15:8] = rx_byte;
    end
    ubx_off_inc = offset_r + 17'd1;
    ubx_done    = (ubx_off_inc == ({1'b0, ubx_len} + nus_pkg::HEADER_AND_CHECKSUM_LEN));
  end

  always_comb begin
    phase_nxt  = phase_r;
    offset_nxt = offset_r;
    caplen_nxt = caplen_r;
    discard    = 1'b0;
    done       = 1'b0;
    tag.proto  = nus_pkg::PROTO_NONE;
    tag.plen   = '0;

    unique case (phase_r)
      PH_IDLE: begin
        if (rx_byte == cfg.nmea_start) begin
          phase_nxt = PH_NMEA;
          if (rx_byte == cfg.nmea_end) begin
            done      = 1'b1;
            tag.proto = nus_pkg::PROTO_NMEA;
          end
        end else if (rx_byte == cfg.ubx_sync1) begin
          phase_nxt  = PH_SYNC2;
          offset_nxt = offset_r + 17'd1;
        end else begin
          discard = 1'b1;
        end
      end
      PH_SYNC2, PH_UBX: begin
        if (phase_r == PH_SYNC2 && rx_byte != cfg.ubx_sync2) begin
          discard = 1'b1;
        end else begin
          phase_nxt  = PH_UBX;
          offset_nxt = ubx_off_inc;
          caplen_nxt = ubx_len;
          if (ubx_done) begin
            done      = 1'b1;
            tag.proto = nus_pkg::PROTO_UBX;
            tag.plen  = ubx_len;
          end
        end
      end
      PH_NMEA: begin
        if (rx_byte == cfg.nmea_start) begin
          discard = 1'b1;
        end else if (rx_byte == cfg.nmea_end) begin
          done      = 1'b1;
          tag.proto = nus_pkg::PROTO_NMEA;
        end
      end
    endcase

    // drop back to idle on discard or completion
    if (discard || done) begin
      phase_nxt  = PH_IDLE;
      offset_nxt = '0;
      caplen_nxt = '0;
    end

    if (discard)   tag.status = nus_pkg::ST_DISCARD;
    else if (done) tag.status = nus_pkg::ST_DONE;
    else           tag.status = nus_pkg::ST_CAPTURING;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      offset_r <= '0;
      caplen_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      offset_r <= offset_nxt;
      caplen_r <= caplen_nxt;
    end
  end

endmodule

@@ src/nmea_ubx_frame_splitter_top.sv @@
// Top level of the NMEA/UBX frame splitter: configuration registers, tracker, result register.
// Depends on nus_pkg, nus_tracker and assert_macros.svh.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in_     | in        | in_valid / in_ready  | in_rx_byte
//  out_    | out       | out_valid / out_ready| out_echo_byte, out_frame_status,
//          |           |                      | out_frame_protocol, out_payload_length
//  cfg_    | in        | cfg_wr_en            | cfg_index, cfg_data
//
// Each item gives exactly one result, in the cycle after it is accepted; one item
// may be accepted every cycle while in_ready is high. The tracker's next-state logic
// (a 17-bit add and compare against the captured length) sits between the state
// registers and the result register. in_ready falls only while a result is held
// with out_ready low. Reset (rst_n, synchronous, active low) loads the configuration
// defaults, returns the tracker to idle and empties the result register.
`include "assert_macros.svh"

module nmea_ubx_frame_splitter_top (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_echo_byte,
  output logic [1:0]  out_frame_status,
  output logic [1:0]  out_frame_protocol,
  output logic [15:0] out_payload_length,

  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  nus_pkg::cfg_t cfg_r;
  nus_pkg::tag_t tag;
  nus_pkg::tag_t tag_r;
  logic [7:0]    echo_r;
  logic          out_valid_r;
  logic          in_accept;

  // Accept a new item whenever the result register is empty or being emptied
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  // Configuration registers; writes to indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nmea_start  <= nus_pkg::NMEA_START_RST;
      cfg_r.nmea_end    <= nus_pkg::NMEA_END_RST;
      cfg_r.ubx_sync1   <= nus_pkg::UBX_SYNC1_RST;
      cfg_r.ubx_sync2   <= nus_pkg::UBX_SYNC2_RST;
      cfg_r.len_big_end <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        nus_pkg::CFG_NMEA_START:  cfg_r.nmea_start  <= cfg_data;
        nus_pkg::CFG_NMEA_END:    cfg_r.nmea_end    <= cfg_data;
        nus_pkg::CFG_UBX_SYNC1:   cfg_r.ubx_sync1   <= cfg_data;
        nus_pkg::CFG_UBX_SYNC2:   cfg_r.ubx_sync2   <= cfg_data;
        nus_pkg::CFG_LEN_BIG_END: cfg_r.len_big_end <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Tag each accepted byte and advance the frame state
  nus_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_accept),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .tag     (tag)
  );

  // Result register: hold until taken, reload on every accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      echo_r <= in_rx_byte;
      tag_r  <= tag;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_echo_byte      = echo_r;
  assign out_frame_status   = tag_r.status;
  assign out_frame_protocol = tag_r.proto;
  assign out_payload_length = tag_r.plen;

  // An accepted item shows up as the next result, byte unchanged
  `ASSERT_NEXT(a_item_to_result, clk, rst_n, in_accept,
               out_valid_r && (echo_r == $past(in_rx_byte)), "accepted item lost")

  // Only a completed frame carries a protocol
  `ASSERT_SAME(a_proto_on_done, clk, rst_n,
               out_valid_r && (tag_r.status != nus_pkg::ST_DONE),
               tag_r.proto == nus_pkg::PROTO_NONE, "protocol set without completion")

  // A payload length is only reported with a completed UBX frame
  `ASSERT_SAME(a_plen_ubx_only, clk, rst_n,
               out_valid_r && (tag_r.proto != nus_pkg::PROTO_UBX),
               tag_r.plen == 16'd0, "payload length outside UBX completion")

endmodule

@@ tb/sv/tb_frame_tag_pkg.sv @@
// Byte tagger that tracks NMEA sentences and UBX frames and checks the tag of each result.
// Depends on nus_pkg for the configuration, status and protocol types.
`timescale 1ns / 100ps

package tb_frame_tag_pkg;
  import nus_pkg::*;

  typedef enum logic [1:0] {
    RD_IDLE      = 2'd0,
    RD_SYNC_WAIT = 2'd1,
    RD_NMEA      = 2'd2,
    RD_UBX       = 2'd3
  } rd_phase_t;

  typedef struct packed {
    logic [7:0] echo;
    tag_t       tag;
  } byte_tag_t;

  class tag_tracker;
    cfg_t        cfg;
    rd_phase_t   rd_phase;
    logic [16:0] ubx_count;
    logic [15:0] len_acc;
    byte_tag_t   pending_tags[$];
    int unsigned accepted;
    int unsigned mismatches;

    function new();
      cfg = '{nmea_start: NMEA_START_RST, nmea_end: NMEA_END_RST,
              ubx_sync1: UBX_SYNC1_RST, ubx_sync2: UBX_SYNC2_RST, len_big_end: 1'b0};
      go_idle();
      accepted   = 0;
      mismatches = 0;
    endfunction

    function void go_idle();
      rd_phase  = RD_IDLE;
      ubx_count = '0;
      len_acc   = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] data);
      case (idx)
        CFG_NMEA_START:  cfg.nmea_start  = data;
        CFG_NMEA_END:    cfg.nmea_end    = data;
        CFG_UBX_SYNC1:   cfg.ubx_sync1   = data;
        CFG_UBX_SYNC2:   cfg.ubx_sync2   = data;
        CFG_LEN_BIG_END: cfg.len_big_end = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_tags.size();
    endfunction

    // Work out the tag of one accepted byte and queue it.
    function void take_byte(logic [7:0] b);
      byte_tag_t t;
      logic      drop;
      logic      done;
      logic      lo_byte;
      t.echo       = b;
      t.tag.status = ST_CAPTURING;
      t.tag.proto  = PROTO_NONE;
      t.tag.plen   = '0;
      drop         = 1'b0;
      done         = 1'b0;
      accepted++;
      case (rd_phase)
        RD_IDLE: begin
          if (b == cfg.nmea_start) rd_phase = RD_NMEA;
          else if (b == cfg.ubx_sync1) rd_phase = RD_SYNC_WAIT;
        end
        RD_SYNC_WAIT: begin
          if (b == cfg.ubx_sync2) rd_phase = RD_UBX;
          else drop = 1'b1;
        end
        RD_NMEA: begin
          if (b == cfg.nmea_start) drop = 1'b1;
        end
        default: ;
      endcase
      if (!drop) begin
        case (rd_phase)
          RD_IDLE: drop = 1'b1;
          RD_UBX: begin
            if (ubx_count == LENGTH_FIELD_OFFSET) lo_byte = !cfg.len_big_end;
            else lo_byte = cfg.len_big_end;
            if (ubx_count == LENGTH_FIELD_OFFSET ||
                ubx_count == LENGTH_FIELD_OFFSET + 17'd1) begin
              if (lo_byte) len_acc[7:0] = b;
              else len_acc[15:8] = b;
            end
            ubx_count = ubx_count + 17'd1;
            if (ubx_count == {1'b0, len_acc} + HEADER_AND_CHECKSUM_LEN) begin
              done        = 1'b1;
              t.tag.proto = PROTO_UBX;
              t.tag.plen  = len_acc;
            end
          end
          RD_NMEA: begin
            if (b == cfg.nmea_end) begin
              done        = 1'b1;
              t.tag.proto = PROTO_NMEA;
            end
          end
          default: ubx_count = ubx_count + 17'd1;
        endcase
      end
      if (drop) begin
        t.tag.status = ST_DISCARD;
        go_idle();
      end else if (done) begin
        t.tag.status = ST_DONE;
        go_idle();
      end
      pending_tags.push_back(t);
    endfunction

    function void report(string field, logic [15:0] want_v, logic [15:0] got_v);
      if (want_v !== got_v) begin
        mismatches++;
        $display("%0t: %s expected %h, got %h", $time, field, want_v, got_v);
      end
    endfunction

    // Compare one accepted result with the oldest tag waiting.
    function void match_tag(logic [7:0] echo, logic [1:0] st, logic [1:0] pr,
                            logic [15:0] pl);
      byte_tag_t want;
      if (pending_tags.size() == 0) begin
        mismatches++;
        $display("%0t: result with no tag waiting, expected none, got echo %h",
                 $time, echo);
        return;
      end
      want = pending_tags.pop_front();
      report("echo_byte", 16'(want.echo), 16'(echo));
      report("frame_status", 16'(want.tag.status), 16'(st));
      report("frame_protocol", 16'(want.tag.proto), 16'(pr));
      report("payload_length", want.tag.plen, pl);
    endfunction
  endclass

endpackage

@@ tb/sv/tb_nmea_ubx_frame_splitter_top.sv @@
// Testbench for nmea_ubx_frame_splitter_top: streams directed and random NMEA/UBX traffic
// through several register settings and checks every tag. Depends on nus_pkg and tb_frame_tag_pkg.
`timescale 1ns / 100ps

module tb_nmea_ubx_frame_splitter_top;
  import nus_pkg::*;
  import tb_frame_tag_pkg::*;

  // An index past the register list; writes to it must change nothing
  localparam logic [2:0] CFG_UNUSED     = 3'd5;
  localparam int         SETTLE_CYCLES  = 3;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         HOLD_AFTER     = 150;
  localparam int         WATCHDOG_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_echo_byte;
  logic [1:0]  out_frame_status;
  logic [1:0]  out_frame_protocol;
  logic [15:0] out_payload_length;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [7:0]  cfg_data = 8'h00;

  tag_tracker  tracker = new();
  logic [7:0]  tx_bytes[$];

  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned stall_cycles = 0;

  always #6 clk = ~clk;

  nmea_ubx_frame_splitter_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_echo_byte      (out_echo_byte),
    .out_frame_status   (out_frame_status),
    .out_frame_protocol (out_frame_protocol),
    .out_payload_length (out_payload_length),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Random byte that differs from both given values.
  function automatic logic [7:0] pick_other(logic [7:0] a, logic [7:0] b);
    logic [7:0] v;
    v = 8'($urandom);
    while (v == a || v == b) v = 8'($urandom);
    return v;
  endfunction

  // Queue a well-formed UBX frame under the current settings: sync pair, class, id,
  // length in the configured byte order, payload and two checksum bytes.
  function automatic void queue_ubx(int unsigned len);
    logic [15:0] l;
    l = 16'(len);
    tx_bytes.push_back(tracker.cfg.ubx_sync1);
    tx_bytes.push_back(tracker.cfg.ubx_sync2);
    tx_bytes.push_back(8'($urandom));
    tx_bytes.push_back(8'($urandom));
    if (tracker.cfg.len_big_end) begin
      tx_bytes.push_back(l[15:8]);
      tx_bytes.push_back(l[7:0]);
    end else begin
      tx_bytes.push_back(l[7:0]);
      tx_bytes.push_back(l[15:8]);
    end
    repeat (len + 2) tx_bytes.push_back(8'($urandom));
  endfunction

  // Queue about n bytes of mostly well-formed traffic with random content; the rest is
  // broken frames and line noise.
  function automatic void queue_traffic(int unsigned n);
    int unsigned base;
    logic [7:0]  st;
    logic [7:0]  en;
    base = tx_bytes.size();
    st   = tracker.cfg.nmea_start;
    en   = tracker.cfg.nmea_end;
    while (tx_bytes.size() - base < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: queue_ubx($urandom_range(0, 12));
        4, 5, 6: begin
          tx_bytes.push_back(st);
          repeat ($urandom_range(0, 12)) tx_bytes.push_back(pick_other(st, en));
          tx_bytes.push_back(en);
        end
        7: begin
          // UBX frame whose second sync byte never comes
          tx_bytes.push_back(tracker.cfg.ubx_sync1);
          tx_bytes.push_back(pick_other(tracker.cfg.ubx_sync2, tracker.cfg.ubx_sync2));
        end
        8: begin
          // sentence cut short by a fresh start character
          tx_bytes.push_back(st);
          repeat ($urandom_range(0, 4)) tx_bytes.push_back(pick_other(st, en));
          tx_bytes.push_back(st);
        end
        default: repeat ($urandom_range(1, 3)) tx_bytes.push_back(8'($urandom));
      endcase
    end
  endfunction

  // Offer the queued bytes in bursts of random length with random gaps. Valid stays
  // high across a burst; the payload moves only once the current item is taken.
  task automatic send_queue();
    int unsigned burst;
    int unsigned gap;
    while (tx_bytes.size() > 0) begin
      burst = $urandom_range(1, 24);
      gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      while (burst > 0 && tx_bytes.size() > 0) begin
        in_valid   <= 1'b1;
        in_rx_byte <= tx_bytes[0];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.take_byte(tx_bytes.pop_front());
        burst--;
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // Wait for every tag to come back, then give the result register time to drain.
  task automatic settle();
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write every register, plus one write to an index past the list. Only called while
  // the sender is idle and nothing is outstanding.
  task automatic apply_cfg(cfg_t c);
    logic [2:0] idx [6];
    logic [7:0] val [6];
    idx = '{CFG_UNUSED, CFG_NMEA_START, CFG_NMEA_END, CFG_UBX_SYNC1, CFG_UBX_SYNC2,
            CFG_LEN_BIG_END};
    val = '{8'($urandom), c.nmea_start, c.nmea_end, c.ubx_sync1, c.ubx_sync2,
            {7'($urandom), c.len_big_end}};
    foreach (idx[i]) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      tracker.write_reg(idx[i], val[i]);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Receiver: check each accepted result, then choose out_ready for the next edge.
  // Once enough items have gone in, hold off for a long stretch so the result
  // register fills and in_ready drops while the sender keeps offering.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        tracker.match_tag(out_echo_byte, out_frame_status, out_frame_protocol,
                          out_payload_length);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && tracker.accepted >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        // rotate through always ready, mostly ready, periodic and coin-flip stalls
        case ((rx_cycle / 64) % 4)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= (rx_cycle % 3 == 0);
          default: out_ready <= 1'($urandom_range(0, 1));
        endcase
      end
      rx_cycle++;
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    // Reset settings: stray idle bytes at both extremes, short and minimal sentences,
    // a start inside a sentence, a missing second sync (the bad byte is not looked at
    // again as a new sync), then zero- and one-byte UBX payloads.
    tx_bytes = {8'h00, 8'hFF,
                NMEA_START_RST, 8'h41, NMEA_END_RST,
                NMEA_START_RST, NMEA_END_RST,
                NMEA_START_RST, 8'h42, NMEA_START_RST,
                UBX_SYNC1_RST, 8'h00,
                UBX_SYNC1_RST, UBX_SYNC1_RST,
                UBX_SYNC1_RST, UBX_SYNC2_RST, 8'h05, 8'h01, 8'h00, 8'h00, 8'hAA, 8'h55};
    queue_ubx(1);
    queue_traffic(40);
    // stop part-way through a UBX header, just before the length field
    tx_bytes.push_back(UBX_SYNC1_RST);
    tx_bytes.push_back(UBX_SYNC2_RST);
    tx_bytes.push_back(8'h0A);
    tx_bytes.push_back(8'h0B);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_queue();
    settle();

    // Flip the length byte order while that frame is still open; the length bytes
    // that follow must be read big-endian (length 3).
    apply_cfg('{nmea_start: NMEA_START_RST, nmea_end: NMEA_END_RST,
                ubx_sync1: UBX_SYNC1_RST, ubx_sync2: UBX_SYNC2_RST, len_big_end: 1'b1});
    tx_bytes = {8'h00, 8'h03};
    repeat (5) tx_bytes.push_back(8'($urandom));
    queue_traffic(30);
    send_queue();
    settle();

    // Extreme characters, little-endian, with a longer frame whose length uses both bytes.
    apply_cfg('{nmea_start: 8'h00, nmea_end: 8'hFF, ubx_sync1: 8'hFF, ubx_sync2: 8'h00,
                len_big_end: 1'b0});
    queue_ubx(258);
    queue_traffic(20);
    send_queue();
    settle();

    // Start, end and first sync all alike: a lone start byte completes a sentence and
    // the NMEA meaning takes precedence over UBX.
    apply_cfg('{nmea_start: 8'h7E, nmea_end: 8'h7E, ubx_sync1: 8'h7E, ubx_sync2: 8'h81,
                len_big_end: 1'b1});
    tx_bytes = {8'h7E, 8'h7E};
    queue_traffic(20);
    send_queue();
    settle();

    // Back to the standard characters: one short big-endian frame, then a tail.
    apply_cfg('{nmea_start: NMEA_START_RST, nmea_end: NMEA_END_RST,
                ubx_sync1: UBX_SYNC1_RST, ubx_sync2: UBX_SYNC2_RST, len_big_end: 1'b1});
    queue_ubx(3);
    queue_traffic(10);
    send_queue();
    settle();

    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
